// ===== rtl/core/fstp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fstp_pkg;

    localparam int unsigned INTERVAL_W = 20;
    localparam logic [INTERVAL_W-1:0] DEFAULT_INTERVAL_US = 20'd16667;

    localparam int unsigned HISTORY_DEPTH_DEFAULT = 3;

    localparam int unsigned FRAME_W = 32;
    localparam int unsigned TIME_W  = 64;
    localparam int unsigned OUT_W   = 32;

    // Microseconds to milliseconds: a shift by three, then long division by 125
    // one 16-bit digit per pipeline step.
    localparam int unsigned MS_SHIFT     = 3;
    localparam int unsigned DIGIT_W      = 16;
    localparam int unsigned REM_W        = 7;
    localparam int unsigned PART_W       = REM_W + DIGIT_W;
    localparam int unsigned RECIP_W      = 24;
    localparam int unsigned RECIP_SHIFT  = 30;
    localparam logic [RECIP_W-1:0] DIGIT_RECIP = 24'd8589935;

    typedef enum logic [2:0] {
        ACT_SYNC    = 3'd0,
        ACT_PREDICT = 3'd1,
        ACT_SUSPEND = 3'd2,
        ACT_RESUME  = 3'd3,
        ACT_WAKE    = 3'd4
    } t_action;

    typedef struct packed {
        logic [DIGIT_W-1:0] quo;
        logic [REM_W-1:0]   rem;
    } t_digit;

endpackage

`default_nettype wire

// ===== rtl/core/frame_sync_time_predictor_top.sv =====
// Display sync time predictor.
// Input channel: i_in_valid / o_in_ready move one event word (action, frame number,
// time in microseconds). Output channel: o_out_valid / i_out_ready move one
// prediction word (delta in microseconds, last sync and next sync in milliseconds).
// Only a predict event while running produces an output word; all other events
// update the state and produce nothing.
// The user must write the configuration register with i_cfg_we and i_cfg_wdata
// only while idle; the block does not enforce this. Throughput is one event per
// cycle while the output is not stalled. A prediction passes one input register,
// four stages for the history average, the span multiply and the 64-bit add, four
// digit steps of the division by 1000, and the output register.
// Reset clears the pipeline and returns the interval to 16667 us, the block to
// running, and all times, counters and history to zero.
// When the receiver stalls, the output word holds and empty stages behind it still
// fill, so events keep being accepted until every stage is occupied.
`timescale 1ns / 1ps
`default_nettype none

module frame_sync_time_predictor_top
    import fstp_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [INTERVAL_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_action,
    input  logic [FRAME_W-1:0]    i_frame_number,
    input  logic [TIME_W-1:0]     i_time_us,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_W-1:0]      o_last_delta_us,
    output logic [OUT_W-1:0]      o_last_sync_ms,
    output logic [OUT_W-1:0]      o_next_sync_ms
);

    localparam int unsigned POS_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HISTORY_DEPTH - 1);
    localparam int unsigned AVG_SHIFT = FRAME_W + POS_W;
    localparam int unsigned AVG_RW = AVG_SHIFT + 1;
    localparam int unsigned AVG_PW = FRAME_W + AVG_RW;
    localparam logic [AVG_RW-1:0] AVG_RECIP = AVG_RW'(((65'd1 << AVG_SHIFT)
        + 65'(HISTORY_DEPTH) - 65'd1) / 65'(HISTORY_DEPTH));

    // Configuration and predictor state.
    logic [INTERVAL_W-1:0] r_interval;
    logic                  r_running, n_running;
    logic                  r_first, n_first;
    logic [TIME_W-1:0]     r_sync_time, n_sync_time;
    logic [TIME_W-1:0]     r_sync_at_upd, n_sync_at_upd;
    logic [FRAME_W-1:0]    r_sync_frame, n_sync_frame;
    logic [FRAME_W-1:0]    r_update_frame, n_update_frame;
    logic [FRAME_W-1:0]    r_hist [HISTORY_DEPTH];
    logic [FRAME_W-1:0]    n_hist [HISTORY_DEPTH];
    logic [POS_W-1:0]      r_hist_pos, n_hist_pos;
    logic [FRAME_W-1:0]    r_hist_sum, n_hist_sum;
    logic [FRAME_W-1:0]    r_extra, n_extra;

    // Pipeline.
    logic                  r_s0_vld;
    logic [2:0]            r_s0_action;
    logic [FRAME_W-1:0]    r_s0_frame;
    logic [TIME_W-1:0]     r_s0_time;

    logic                  r_s1_vld, n_s1_vld;
    logic [TIME_W-1:0]     r_s1_last;
    logic [OUT_W-1:0]      r_s1_delta, n_s1_delta;
    logic                  r_s1_use_avg, n_s1_use_avg;
    logic [FRAME_W-1:0]    r_s1_till, n_s1_till;
    logic [FRAME_W-1:0]    r_s1_sum;

    logic                  r_s2_vld;
    logic [TIME_W-1:0]     r_s2_last;
    logic [OUT_W-1:0]      r_s2_delta;
    logic                  r_s2_use_avg;
    logic [FRAME_W-1:0]    r_s2_till;
    logic [FRAME_W-1:0]    r_s2_avg;

    logic                  r_s3_vld;
    logic [TIME_W-1:0]     r_s3_last;
    logic [OUT_W-1:0]      r_s3_delta;
    logic [OUT_W-1:0]      r_s3_span;

    logic                  r_s4_vld;
    logic [TIME_W-1:0]     r_s4_x_a;
    logic [TIME_W-1:0]     r_s4_x_b;
    logic [OUT_W-1:0]      r_s4_delta;

    logic                  r_out_vld;
    logic [OUT_W-1:0]      r_out_delta;
    logic [OUT_W-1:0]      r_out_last;
    logic [OUT_W-1:0]      r_out_next;

    logic                  go0, go1, go2, go3, go4, go_div, go_out;
    logic                  s0_fire;
    logic [FRAME_W-1:0]    frames;
    logic [TIME_W-1:0]     delta_full;
    logic [AVG_PW-1:0]     avg_prod;
    logic [FRAME_W-1:0]    s2_till;
    logic [OUT_W-1:0]      s2_span;
    logic                  div_vld;
    logic [OUT_W-1:0]      div_q_a, div_q_b, div_tag;
    logic [FRAME_W-1:0]    hist_total;

    assign go_out = !r_out_vld || i_out_ready;
    assign go4    = !r_s4_vld || go_div;
    assign go3    = !r_s3_vld || go4;
    assign go2    = !r_s2_vld || go3;
    assign go1    = !r_s1_vld || go2;
    assign go0    = !r_s0_vld || go1;
    assign s0_fire = r_s0_vld && go1;

    assign o_in_ready = go0;

    assign frames     = r_sync_frame - r_update_frame;
    assign delta_full = r_sync_time - r_sync_at_upd;
    assign n_s1_delta = (|delta_full[TIME_W-1:OUT_W]) ? '1 : delta_full[OUT_W-1:0];

    always_comb begin
        n_running      = r_running;
        n_first        = r_first;
        n_sync_time    = r_sync_time;
        n_sync_at_upd  = r_sync_at_upd;
        n_sync_frame   = r_sync_frame;
        n_update_frame = r_update_frame;
        n_hist         = r_hist;
        n_hist_pos     = r_hist_pos;
        n_hist_sum     = r_hist_sum;
        n_extra        = r_extra;
        n_s1_vld       = 1'b0;
        n_s1_use_avg   = 1'b0;
        n_s1_till      = FRAME_W'(1);
        if (s0_fire) begin
            case (r_s0_action)
                ACT_SYNC: begin
                    if (r_running) begin
                        n_sync_time  = r_s0_time;
                        n_sync_frame = r_s0_frame;
                    end
                end
                ACT_PREDICT: begin
                    if (r_running) begin
                        n_s1_vld = 1'b1;
                        if (!r_first) begin
                            if (frames == '0) begin
                                n_extra   = r_extra + FRAME_W'(1);
                                n_s1_till = r_extra + FRAME_W'(2);
                            end else begin
                                n_extra = '0;
                            end
                            n_s1_use_avg       = (frames > FRAME_W'(1));
                            n_hist[r_hist_pos] = frames;
                            n_hist_sum = r_hist_sum - r_hist[r_hist_pos] + frames;
                            n_hist_pos = (r_hist_pos == POS_LAST) ? '0
                                                                  : r_hist_pos + POS_W'(1);
                        end
                        n_update_frame = r_sync_frame;
                        n_sync_at_upd  = r_sync_time;
                        n_first        = 1'b0;
                    end
                end
                ACT_SUSPEND: begin
                    n_running      = 1'b0;
                    n_sync_frame   = '0;
                    n_update_frame = '0;
                    n_hist_pos     = '0;
                    n_hist_sum     = '0;
                    n_extra        = '0;
                    for (int i = 0; i < HISTORY_DEPTH; i++) begin
                        n_hist[i] = '0;
                    end
                end
                ACT_RESUME, ACT_WAKE: begin
                    n_sync_time = r_s0_time;
                    if (r_s0_action == ACT_WAKE) begin
                        n_sync_at_upd = r_s0_time;
                    end
                    n_first   = 1'b1;
                    n_running = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval     <= DEFAULT_INTERVAL_US;
            r_running      <= 1'b1;
            r_first        <= 1'b1;
            r_sync_time    <= '0;
            r_sync_at_upd  <= '0;
            r_sync_frame   <= '0;
            r_update_frame <= '0;
            r_hist_pos     <= '0;
            r_hist_sum     <= '0;
            r_extra        <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            r_running      <= n_running;
            r_first        <= n_first;
            r_sync_time    <= n_sync_time;
            r_sync_at_upd  <= n_sync_at_upd;
            r_sync_frame   <= n_sync_frame;
            r_update_frame <= n_update_frame;
            r_hist         <= n_hist;
            r_hist_pos     <= n_hist_pos;
            r_hist_sum     <= n_hist_sum;
            r_extra        <= n_extra;
        end
    end

    assign avg_prod = AVG_PW'(r_s1_sum) * AVG_PW'(AVG_RECIP);
    assign s2_till  = (r_s2_use_avg && r_s2_avg > FRAME_W'(1)) ? r_s2_avg : r_s2_till;
    assign s2_span  = OUT_W'(r_interval) * s2_till;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (go0) begin
                r_s0_vld <= i_in_valid;
            end
            if (go1) begin
                r_s1_vld <= n_s1_vld;
            end
            if (go2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (go3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (go4) begin
                r_s4_vld <= r_s3_vld;
            end
            if (go_out) begin
                r_out_vld <= div_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go0) begin
            r_s0_action <= i_action;
            r_s0_frame  <= i_frame_number;
            r_s0_time   <= i_time_us;
        end
        if (go1) begin
            r_s1_last    <= r_sync_time;
            r_s1_delta   <= n_s1_delta;
            r_s1_use_avg <= n_s1_use_avg;
            r_s1_till    <= n_s1_till;
            r_s1_sum     <= r_hist_sum;
        end
        if (go2) begin
            r_s2_last    <= r_s1_last;
            r_s2_delta   <= r_s1_delta;
            r_s2_use_avg <= r_s1_use_avg;
            r_s2_till    <= r_s1_till;
            r_s2_avg     <= avg_prod[AVG_SHIFT +: FRAME_W];
        end
        if (go3) begin
            r_s3_last  <= r_s2_last;
            r_s3_delta <= r_s2_delta;
            r_s3_span  <= s2_span;
        end
        if (go4) begin
            r_s4_x_a   <= r_s3_last;
            r_s4_x_b   <= r_s3_last + TIME_W'(r_s3_span);
            r_s4_delta <= r_s3_delta;
        end
        if (go_out) begin
            r_out_delta <= div_tag;
            r_out_last  <= div_q_a;
            r_out_next  <= div_q_b;
        end
    end

    fstp_div1000 u_div1000 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r_s4_vld),
        .i_x_a     (r_s4_x_a),
        .i_x_b     (r_s4_x_b),
        .i_tag     (r_s4_delta),
        .i_go_next (go_out),
        .o_go      (go_div),
        .o_vld     (div_vld),
        .o_q_a     (div_q_a),
        .o_q_b     (div_q_b),
        .o_tag     (div_tag)
    );

    assign o_out_valid     = r_out_vld;
    assign o_last_delta_us = r_out_delta;
    assign o_last_sync_ms  = r_out_last;
    assign o_next_sync_ms  = r_out_next;

    always_comb begin
        hist_total = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_total = hist_total + r_hist[i];
        end
    end

    a_hist_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hist_sum == hist_total)
        else $error("Running history sum differs from the stored history.");

    a_hist_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hist_pos <= POS_LAST)
        else $error("History position is past the last entry.");

    a_wake_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s0_fire && r_s0_action == ACT_WAKE |=> r_sync_time == r_sync_at_upd)
        else $error("Wake did not align the update time with the sync time.");

    a_suspend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s0_fire && r_s0_action == ACT_SUSPEND |=>
            !r_running && r_extra == '0 && r_hist_sum == '0)
        else $error("Suspend left the predictor running or its counters set.");

endmodule

`default_nettype wire

// ===== rtl/core/fstp_div1000.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fstp_div1000
    import fstp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [TIME_W-1:0] i_x_a,
    input  logic [TIME_W-1:0] i_x_b,
    input  logic [OUT_W-1:0]  i_tag,
    input  logic              i_go_next,
    output logic              o_go,
    output logic              o_vld,
    output logic [OUT_W-1:0]  o_q_a,
    output logic [OUT_W-1:0]  o_q_b,
    output logic [OUT_W-1:0]  o_tag
);

    localparam int unsigned STEPS = TIME_W / DIGIT_W;
    localparam int unsigned PROD_W = PART_W + RECIP_W;

    // The reciprocal is exact for every partial dividend below 125 * 2^16.
    function automatic t_digit f_step(input logic [REM_W-1:0] rem_in,
                                      input logic [DIGIT_W-1:0] chunk);
        logic [PART_W-1:0]  v;
        logic [PROD_W-1:0]  prod;
        logic [DIGIT_W-1:0] q;
        logic [PART_W-1:0]  qm;
        t_digit             res;
        v    = {rem_in, chunk};
        prod = PROD_W'(v) * PROD_W'(DIGIT_RECIP);
        q    = prod[RECIP_SHIFT +: DIGIT_W];
        // q * 125 as 128q - 4q + q.
        qm   = (PART_W'(q) << 7) - (PART_W'(q) << 2) + PART_W'(q);
        res.quo = q;
        res.rem = REM_W'(v - qm);
        return res;
    endfunction

    logic               r_vld   [STEPS];
    logic [TIME_W-1:0]  r_y_a   [STEPS];
    logic [TIME_W-1:0]  r_y_b   [STEPS];
    logic [REM_W-1:0]   r_rem_a [STEPS];
    logic [REM_W-1:0]   r_rem_b [STEPS];
    logic [OUT_W-1:0]   r_q_a   [STEPS];
    logic [OUT_W-1:0]   r_q_b   [STEPS];
    logic [OUT_W-1:0]   r_tag   [STEPS];

    logic               go      [STEPS+1];
    logic               src_vld [STEPS];
    logic [TIME_W-1:0]  src_y_a [STEPS];
    logic [TIME_W-1:0]  src_y_b [STEPS];
    logic [REM_W-1:0]   src_r_a [STEPS];
    logic [REM_W-1:0]   src_r_b [STEPS];
    logic [OUT_W-1:0]   src_q_a [STEPS];
    logic [OUT_W-1:0]   src_q_b [STEPS];
    logic [OUT_W-1:0]   src_tag [STEPS];
    t_digit             d_a     [STEPS];
    t_digit             d_b     [STEPS];

    assign go[STEPS] = i_go_next;
    assign o_go      = go[0];

    assign src_vld[0] = i_vld;
    assign src_y_a[0] = i_x_a >> MS_SHIFT;
    assign src_y_b[0] = i_x_b >> MS_SHIFT;
    assign src_r_a[0] = '0;
    assign src_r_b[0] = '0;
    assign src_q_a[0] = '0;
    assign src_q_b[0] = '0;
    assign src_tag[0] = i_tag;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        if (k > 0) begin : g_link
            assign src_vld[k] = r_vld[k-1];
            assign src_y_a[k] = r_y_a[k-1];
            assign src_y_b[k] = r_y_b[k-1];
            assign src_r_a[k] = r_rem_a[k-1];
            assign src_r_b[k] = r_rem_b[k-1];
            assign src_q_a[k] = r_q_a[k-1];
            assign src_q_b[k] = r_q_b[k-1];
            assign src_tag[k] = r_tag[k-1];
        end

        assign go[k] = !r_vld[k] || go[k+1];

        assign d_a[k] = f_step(src_r_a[k],
                               src_y_a[k][TIME_W-1-k*DIGIT_W -: DIGIT_W]);
        assign d_b[k] = f_step(src_r_b[k],
                               src_y_b[k][TIME_W-1-k*DIGIT_W -: DIGIT_W]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (go[k]) begin
                r_vld[k] <= src_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (go[k]) begin
                r_y_a[k]   <= src_y_a[k];
                r_y_b[k]   <= src_y_b[k];
                r_rem_a[k] <= d_a[k].rem;
                r_rem_b[k] <= d_b[k].rem;
                r_q_a[k]   <= {src_q_a[k][OUT_W-DIGIT_W-1:0], d_a[k].quo};
                r_q_b[k]   <= {src_q_b[k][OUT_W-DIGIT_W-1:0], d_b[k].quo};
                r_tag[k]   <= src_tag[k];
            end
        end
    end

    assign o_vld = r_vld[STEPS-1];
    assign o_q_a = r_q_a[STEPS-1];
    assign o_q_b = r_q_b[STEPS-1];
    assign o_tag = r_tag[STEPS-1];

endmodule

`default_nettype wire

// ===== tb/sv/frame_sync_time_predictor_top_tb.sv =====
`timescale 1ns / 1ps

module frame_sync_time_predictor_top_tb;
    import fstp_pkg::*;

    localparam int HIST = HISTORY_DEPTH_DEFAULT;
    localparam int CLK_HALF = 4;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD = 80;
    localparam int PHASE_EVENTS = 190;
    localparam int PRESSURE_EVENTS = 150;
    localparam logic [TIME_W-1:0] US_PER_MS = 64'd1000;
    localparam logic [TIME_W-1:0] DELTA_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MIN = 20'd0;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 20'd1000000;
    localparam logic [2:0] FIRST_UNUSED_ACTION = 3'd5;
    localparam logic [2:0] LAST_UNUSED_ACTION = 3'd7;

    typedef struct packed {
        logic [2:0]         action;
        logic [FRAME_W-1:0] frame;
        logic [TIME_W-1:0]  time_us;
    } t_sync_event;

    typedef struct packed {
        logic [OUT_W-1:0] delta_us;
        logic [OUT_W-1:0] last_ms;
        logic [OUT_W-1:0] next_ms;
    } t_sync_report;

    typedef enum {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PATTERN} t_ready_mode;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [INTERVAL_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [2:0]            i_action = '0;
    logic [FRAME_W-1:0]    i_frame_number = '0;
    logic [TIME_W-1:0]     i_time_us = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    logic [OUT_W-1:0]      o_last_delta_us;
    logic [OUT_W-1:0]      o_last_sync_ms;
    logic [OUT_W-1:0]      o_next_sync_ms;

    // Predictor state.
    logic [INTERVAL_W-1:0] m_interval;
    logic                  m_running;
    logic                  m_first;
    logic [TIME_W-1:0]     m_sync_time;
    logic [TIME_W-1:0]     m_time_at_update;
    logic [FRAME_W-1:0]    m_sync_frame;
    logic [FRAME_W-1:0]    m_update_frame;
    logic [FRAME_W-1:0]    m_history [HIST];
    int                    m_hist_pos;
    logic [31:0]           m_extra;

    t_sync_event  pending_events [$];
    t_sync_report predicted_reports [$];
    t_sync_event  offered;
    t_sync_report want;
    int           events_queued = 0;
    int           events_taken = 0;
    int           mismatches = 0;
    int           cycle_count = 0;
    bit           sender_gaps = 1'b1;
    int           burst_left = 0;
    int           gap_left = 0;
    int           hold_reqs = 0;
    int           hold_served = 0;
    int           hold_left = 0;
    int           mode_left = 0;
    t_ready_mode  ready_mode = READY_ALWAYS;
    logic [FRAME_W-1:0] cur_frame;
    logic [TIME_W-1:0]  cur_time;

    frame_sync_time_predictor_top #(
        .HISTORY_DEPTH(HIST)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_action(i_action),
        .i_frame_number(i_frame_number),
        .i_time_us(i_time_us),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_last_delta_us(o_last_delta_us),
        .o_last_sync_ms(o_last_sync_ms),
        .o_next_sync_ms(o_next_sync_ms)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic reset_predictor;
        int i;
        m_interval = DEFAULT_INTERVAL_US;
        m_running = 1'b1;
        m_first = 1'b1;
        m_sync_time = '0;
        m_time_at_update = '0;
        m_sync_frame = '0;
        m_update_frame = '0;
        for (i = 0; i < HIST; i++) m_history[i] = '0;
        m_hist_pos = 0;
        m_extra = '0;
    endtask

    task automatic clear_frame_counters;
        int i;
        m_sync_frame = '0;
        m_update_frame = '0;
        for (i = 0; i < HIST; i++) m_history[i] = '0;
        m_hist_pos = 0;
        m_extra = '0;
    endtask

    // Advances the predictor by one accepted word and queues the prediction it causes.
    task automatic apply_sync_event(input t_sync_event ev);
        logic [TIME_W-1:0]  last_us;
        logic [TIME_W-1:0]  delta;
        logic [TIME_W-1:0]  next_us;
        logic [TIME_W-1:0]  quot;
        logic [FRAME_W-1:0] frames;
        logic [31:0]        till;
        logic [31:0]        hist_sum;
        logic [31:0]        avg;
        logic [31:0]        span;
        t_sync_report       rep;
        int                 i;
        case (ev.action)
            ACT_SYNC: begin
                if (m_running) begin
                    m_sync_time = ev.time_us;
                    m_sync_frame = ev.frame;
                end
            end
            ACT_SUSPEND: begin
                m_running = 1'b0;
                clear_frame_counters();
            end
            ACT_RESUME, ACT_WAKE: begin
                m_sync_time = ev.time_us;
                if (ev.action == ACT_WAKE) m_time_at_update = ev.time_us;
                m_first = 1'b1;
                m_running = 1'b1;
            end
            ACT_PREDICT: begin
                if (m_running) begin
                    last_us = m_sync_time;
                    frames = m_sync_frame - m_update_frame;
                    till = 32'd1;
                    delta = last_us - m_time_at_update;
                    if (!m_first) begin
                        if (frames == '0) begin
                            m_extra = m_extra + 32'd1;
                            till = m_extra + 32'd1;
                        end else begin
                            m_extra = '0;
                        end
                        if (frames > 32'd1) begin
                            hist_sum = '0;
                            for (i = 0; i < HIST; i++) hist_sum = hist_sum + m_history[i];
                            avg = hist_sum / HIST;
                            if (avg > 32'd1) till = avg;
                        end
                        m_history[m_hist_pos] = frames;
                        m_hist_pos = (m_hist_pos + 1) % HIST;
                    end
                    m_update_frame = m_sync_frame;
                    m_time_at_update = last_us;
                    m_first = 1'b0;
                    span = 32'(m_interval) * till;
                    rep.delta_us = (delta > DELTA_MAX) ? '1 : delta[OUT_W-1:0];
                    quot = last_us / US_PER_MS;
                    rep.last_ms = quot[OUT_W-1:0];
                    next_us = last_us + {32'd0, span};
                    quot = next_us / US_PER_MS;
                    rep.next_ms = quot[OUT_W-1:0];
                    predicted_reports.push_back(rep);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Sender: bursts of words separated by random gaps while sender_gaps is set, else back-to-back words.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                apply_sync_event(offered);
                events_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    offered = pending_events.pop_front();
                    i_action <= offered.action;
                    i_frame_number <= offered.frame;
                    i_time_us <= offered.time_us;
                    i_in_valid <= 1'b1;
                    if (sender_gaps) begin
                        if (burst_left == 0) begin
                            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                     : $urandom_range(1, 8);
                        end
                        burst_left--;
                        if (burst_left == 0) gap_left = $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each word and stalls on a pattern of its own.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_reports.size() == 0) begin
                    report_mismatch($sformatf("word with nothing expected: delta %0d last %0d next %0d",
                                              o_last_delta_us, o_last_sync_ms, o_next_sync_ms));
                end else begin
                    want = predicted_reports.pop_front();
                    if (o_last_delta_us !== want.delta_us) begin
                        report_mismatch($sformatf("last_delta_us got %0d expected %0d",
                                                  o_last_delta_us, want.delta_us));
                    end
                    if (o_last_sync_ms !== want.last_ms) begin
                        report_mismatch($sformatf("last_sync_ms got %0d expected %0d",
                                                  o_last_sync_ms, want.last_ms));
                    end
                    if (o_next_sync_ms !== want.next_ms) begin
                        report_mismatch($sformatf("next_sync_ms got %0d expected %0d",
                                                  o_next_sync_ms, want.next_ms));
                    end
                end
            end
            if (hold_served != hold_reqs) begin
                hold_left = LONG_HOLD;
                hold_served++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = t_ready_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (ready_mode)
                    READY_ALWAYS: i_out_ready <= 1'b1;
                    READY_COIN: i_out_ready <= ($urandom_range(0, 1) != 0);
                    READY_MOSTLY: i_out_ready <= ($urandom_range(0, 3) != 0);
                    default: i_out_ready <= ((mode_left % 5) < 3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_event(input logic [2:0] act, input logic [FRAME_W-1:0] frame,
                               input logic [TIME_W-1:0] t_us);
        t_sync_event ev;
        ev.action = act;
        ev.frame = frame;
        ev.time_us = t_us;
        pending_events.push_back(ev);
        events_queued++;
    endtask

    task automatic wait_drained;
        while (events_taken != events_queued || predicted_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [INTERVAL_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_interval = value;
    endtask

    task automatic start_timeline;
        cur_frame = $urandom;
        if ($urandom_range(0, 2) == 0) begin
            cur_time = '1 - {$urandom_range(0, 255), $urandom};
        end else begin
            cur_time = {$urandom_range(0, 3) == 0 ? $urandom : 32'd0, $urandom};
        end
    endtask

    task automatic advance_sync;
        logic [31:0] step;
        int          pick;
        pick = $urandom_range(0, 19);
        if (pick < 2) step = 32'd0;
        else if (pick < 12) step = 32'd1;
        else if (pick < 18) step = $urandom_range(2, 5);
        else if (pick < 19) step = $urandom_range(6, 40);
        else step = $urandom;
        cur_frame = cur_frame + step;
        if ($urandom_range(0, 29) == 0) begin
            cur_time = cur_time + {$urandom_range(1, 255), $urandom};
        end else begin
            cur_time = cur_time + TIME_W'(step) * TIME_W'(m_interval)
                       + TIME_W'($urandom_range(0, 3000));
        end
    endtask

    // Mostly well-formed sync and predict streams, with power events and noise mixed in.
    task automatic gen_traffic(input int count);
        int made;
        int pick;
        made = 0;
        start_timeline();
        if ($urandom_range(0, 1) == 0) queue_event(ACT_RESUME, $urandom, cur_time);
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                advance_sync();
                queue_event(ACT_SYNC, cur_frame, cur_time);
            end else if (pick < 75) begin
                queue_event(ACT_PREDICT, $urandom, {$urandom, $urandom});
            end else if (pick < 80) begin
                queue_event(ACT_SUSPEND, $urandom, {$urandom, $urandom});
            end else if (pick < 86) begin
                cur_time = cur_time + TIME_W'($urandom_range(0, 100000));
                queue_event(ACT_RESUME, $urandom, cur_time);
            end else if (pick < 91) begin
                cur_time = cur_time + TIME_W'($urandom_range(0, 100000));
                queue_event(ACT_WAKE, $urandom, cur_time);
            end else if (pick < 96) begin
                queue_event(3'($urandom_range(FIRST_UNUSED_ACTION, LAST_UNUSED_ACTION)),
                            $urandom, {$urandom, $urandom});
                made--;
            end else begin
                queue_event(3'($urandom_range(ACT_SYNC, ACT_WAKE)), $urandom,
                            {$urandom, $urandom});
            end
            made++;
        end
    endtask

    task automatic gen_pressure(input int count);
        int i;
        start_timeline();
        queue_event(ACT_WAKE, $urandom, cur_time);
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                advance_sync();
                queue_event(ACT_SYNC, cur_frame, cur_time);
            end else begin
                queue_event(ACT_PREDICT, $urandom, {$urandom, $urandom});
            end
        end
    endtask

    task automatic run_phase(input logic [INTERVAL_W-1:0] interval, input int count);
        write_interval(interval);
        gen_traffic(count);
        wait_drained();
    endtask

    initial begin
        reset_predictor();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_event(ACT_PREDICT, '0, '0);
        queue_event(ACT_SYNC, 32'd10, 64'd1000);
        queue_event(ACT_PREDICT, '0, '0);
        queue_event(ACT_PREDICT, '0, '0);
        queue_event(ACT_PREDICT, '0, '0);
        queue_event(ACT_SYNC, 32'd13, 64'd51001);
        queue_event(ACT_PREDICT, '0, '0);
        queue_event(ACT_SYNC, 32'd14, 64'd67668);
        queue_event(ACT_PREDICT, '0, '0);
        queue_event(FIRST_UNUSED_ACTION, '1, '1);
        queue_event(FIRST_UNUSED_ACTION + 3'd1, 32'd3, 64'd5);
        queue_event(LAST_UNUSED_ACTION, '0, '0);
        queue_event(ACT_SYNC, '1, '1);
        queue_event(ACT_PREDICT, '1, '1);
        queue_event(ACT_SUSPEND, '0, '0);
        queue_event(ACT_PREDICT, '0, '0);
        queue_event(ACT_SYNC, 32'd5, 64'd7);
        queue_event(ACT_RESUME, '0, 64'h0000_0100_0000_0000);
        queue_event(ACT_PREDICT, '0, '0);
        queue_event(ACT_SUSPEND, '1, '1);
        queue_event(ACT_WAKE, '0, 64'd123456);
        queue_event(ACT_PREDICT, '0, '0);
        queue_event(ACT_SYNC, 32'd1, 64'd140123);
        queue_event(ACT_PREDICT, '0, '0);
        wait_drained();

        run_phase(INTERVAL_MAX, PHASE_EVENTS);
        run_phase(INTERVAL_MIN, PHASE_EVENTS);

        // The receiver holds off while words keep coming, so the pipeline fills.
        write_interval(INTERVAL_W'($urandom_range(1, INTERVAL_MAX)));
        sender_gaps = 1'b0;
        hold_reqs++;
        gen_pressure(PRESSURE_EVENTS);
        wait_drained();
        sender_gaps = 1'b1;

        run_phase(DEFAULT_INTERVAL_US, PHASE_EVENTS);
        run_phase(INTERVAL_W'($urandom_range(1, INTERVAL_MAX)), PHASE_EVENTS);
        run_phase(INTERVAL_W'($urandom_range(1, 100)), PHASE_EVENTS);

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fstp_pkg.sv
rtl/core/fstp_div1000.sv
rtl/core/frame_sync_time_predictor_top.sv
tb/sv/frame_sync_time_predictor_top_tb.sv
